// File: src/llti_pkg.sv
// shared widths, codes, beat types and elaboration-time rom builders
`timescale 1ns / 1ps

package llti_pkg;

    localparam int FRAC             = 28;
    localparam int VAL_W            = 56;
    localparam int LOG_W            = 36;
    localparam int SLOPE_W          = 30;
    localparam int DIFF_W           = 37;
    localparam int PP_W             = 49;
    localparam int PROD_W           = 68;
    localparam int Y_W              = 40;
    localparam int Z_W              = 41;
    localparam int MANT_W           = 32;
    localparam int SHIFT_W          = 6;
    localparam int TBL_MAX          = 16;
    localparam int IDX_W            = 4;
    localparam int TABLE_POINTS_DEF = 10;

    localparam logic [1:0] ACT_WEIGHT = 2'd0;
    localparam logic [1:0] ACT_TEMP   = 2'd1;
    localparam logic [1:0] ACT_ENERGY = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [VAL_W-1:0] value_in;
    } item_t;

    typedef struct packed {
        logic [VAL_W-1:0] value_out;
        logic [1:0]       status;
    } result_t;

    // side info that rides along with each beat
    typedef struct packed {
        logic [1:0] action;
        logic       zero;
    } tag_t;

    typedef longint rom_t [TBL_MAX];
    typedef longint unsigned root_t [FRAC];

    localparam longint unsigned TEMP_INT [TBL_MAX] = '{
        10, 100, 1000, 10000, 13000, 21000, 34000, 63000, 100000,
        1000000000, 0, 0, 0, 0, 0, 0};
    localparam longint unsigned MU_E8 [TBL_MAX] = '{
        118701555, 115484424, 109603514, 99814960, 96346395, 65175895,
        61429010, 60568330, 58977760, 58822635, 0, 0, 0, 0, 0, 0};

    function automatic int npts(input int n);
        int r;
        r = n;
        if (r < 2) r = 2;
        if (r > TBL_MAX) r = TBL_MAX;
        return r;
    endfunction

    function automatic longint lg2q(input longint unsigned x);
        int p;
        longint unsigned m;
        longint frac;
        frac = 0;
        if (x == 0) return -(longint'(24) << FRAC);
        p = 55;
        while (p > 0 && ((x >> p) & 64'd1) == 64'd0) p--;
        if (p >= 31) m = x >> (p - 31);
        else m = x << (31 - p);
        for (int i = 0; i < FRAC; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(p) - 24) * (longint'(1) << FRAC) + frac;
    endfunction

    function automatic longint unsigned isqrt64(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = v_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // restoring long division of magnitudes
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint mkslope(input longint dy, input longint dx);
        longint s;
        longint lim;
        longint num;
        longint unsigned an;
        longint unsigned ad;
        longint unsigned qa;
        bit neg;
        lim = (longint'(1) << 29) - 1;
        if (dx == 0) return 0;
        num = dy * (longint'(1) << FRAC);
        neg = (num < 0) ^ (dx < 0);
        an  = (num < 0) ? longint'(-num) : longint'(num);
        ad  = (dx < 0) ? longint'(-dx) : longint'(dx);
        qa  = udiv64(an, ad);
        s   = neg ? -longint'(qa) : longint'(qa);
        if (s > lim) s = lim;
        if (s < -lim) s = -lim;
        return s;
    endfunction

    function automatic rom_t f_log_t();
        rom_t r;
        for (int i = 0; i < TBL_MAX; i++) r[i] = lg2q(TEMP_INT[i] << 24);
        return r;
    endfunction

    function automatic rom_t f_log_m();
        rom_t r;
        for (int i = 0; i < TBL_MAX; i++)
            r[i] = lg2q(((MU_E8[i] << 24) + 64'd50000000) / 64'd100000000);
        return r;
    endfunction

    function automatic rom_t f_log_u();
        rom_t r;
        rom_t lt;
        rom_t lm;
        lt = f_log_t();
        lm = f_log_m();
        for (int i = 0; i < TBL_MAX; i++) r[i] = lt[i] - lm[i];
        return r;
    endfunction

    function automatic rom_t f_slope_mu(input int n);
        rom_t r;
        rom_t lt;
        rom_t lm;
        lt = f_log_t();
        lm = f_log_m();
        for (int i = 0; i < TBL_MAX; i++) r[i] = 0;
        for (int i = 1; i < npts(n); i++)
            r[i] = mkslope(lm[i] - lm[i-1], lt[i] - lt[i-1]);
        return r;
    endfunction

    function automatic rom_t f_slope_t(input int n);
        rom_t r;
        rom_t lt;
        rom_t lu;
        lt = f_log_t();
        lu = f_log_u();
        for (int i = 0; i < TBL_MAX; i++) r[i] = 0;
        for (int i = 1; i < npts(n); i++)
            r[i] = mkslope(lt[i] - lt[i-1], lu[i] - lu[i-1]);
        return r;
    endfunction

    function automatic root_t f_roots();
        root_t r;
        longint unsigned c;
        c = 64'd1 << 31;
        for (int i = 0; i < FRAC; i++) begin
            c = isqrt64(c << 30);
            r[i] = c;
        end
        return r;
    endfunction

    // entry i holds 2^(2^-(i+1)) in Q30
    localparam root_t ROOTS = f_roots();

endpackage

// File: src/llti_log2.sv
// log2 front end: normalize, then one squaring per stage for each fraction bit
`timescale 1ns / 1ps

module llti_log2
    import llti_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  item_t                   in_item,
    output logic                    out_valid,
    output tag_t                    out_tag,
    output logic signed [LOG_W-1:0] out_log
);

    typedef struct packed {
        tag_t              tag;
        logic [5:0]        p;
        logic [MANT_W-1:0] m;
        logic [FRAC-1:0]   frac;
    } lstage_t;

    lstage_t st_reg  [FRAC+1];
    lstage_t st_next [FRAC+1];
    logic    v_reg   [FRAC+1];

    always_comb
    begin
        logic [5:0]  p;
        logic [63:0] xw;
        logic [63:0] sq;
        logic [32:0] t;
        p  = '0;
        xw = 64'(in_item.value_in);
        for (int i = 0; i < VAL_W; i++)
            if (in_item.value_in[i]) p = 6'(i);
        st_next[0].tag.action = in_item.action;
        st_next[0].tag.zero   = (in_item.value_in == '0);
        st_next[0].p          = p;
        st_next[0].frac       = '0;
        if (p >= 6'd31) st_next[0].m = MANT_W'(xw >> (p - 6'd31));
        else st_next[0].m = MANT_W'(xw << (6'd31 - p));
        for (int k = 1; k <= FRAC; k++)
        begin
            sq = 64'(st_reg[k-1].m) * 64'(st_reg[k-1].m);
            t  = 33'(sq >> 31);
            st_next[k] = st_reg[k-1];
            if (t[32])
            begin
                st_next[k].m    = t[32:1];
                st_next[k].frac = {st_reg[k-1].frac[FRAC-2:0], 1'b1};
            end
            else
            begin
                st_next[k].m    = t[31:0];
                st_next[k].frac = {st_reg[k-1].frac[FRAC-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= FRAC; k++) v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= FRAC; k++) v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= FRAC; k++) st_reg[k] <= st_next[k];
        end
    end

    logic signed [LOG_W-FRAC-1:0] expo;
    assign expo      = $signed({2'b00, st_reg[FRAC].p}) - 8'sd24;
    assign out_log   = {expo, st_reg[FRAC].frac};
    assign out_valid = v_reg[FRAC];
    assign out_tag   = st_reg[FRAC].tag;

endmodule

// File: src/llti_interp.sv
// segment pick, slope multiply and exponent setup in the log2 domain
`timescale 1ns / 1ps

module llti_interp
    import llti_pkg::*;
#(
    parameter int TABLE_POINTS = TABLE_POINTS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  tag_t                    in_tag,
    input  logic signed [LOG_W-1:0] in_log,
    output logic                    out_valid,
    output logic                    out_zero,
    output logic signed [Z_W-1:0]   out_z
);

    localparam int   NP       = npts(TABLE_POINTS);
    localparam rom_t LOG_T    = f_log_t();
    localparam rom_t LOG_M    = f_log_m();
    localparam rom_t LOG_U    = f_log_u();
    localparam rom_t SLOPE_MU = f_slope_mu(TABLE_POINTS);
    localparam rom_t SLOPE_T  = f_slope_t(TABLE_POINTS);
    localparam logic signed [PROD_W-1:0] TRUNC_ADJ = PROD_W'((64'd1 << FRAC) - 64'd1);
    localparam logic signed [Z_W-1:0]    Z_OFS     = Z_W'(64'd24 << FRAC);

    logic [4:0] v_reg;

    // stage 1: segment pick
    tag_t                    tag1_reg;
    logic                    sel1_reg;
    logic [IDX_W-1:0]        j1_reg;
    logic signed [LOG_W-1:0] l1_reg;
    logic [IDX_W-1:0]        j1_next;
    logic                    sel1_next;

    always_comb
    begin
        logic signed [LOG_W-1:0] lxv;
        sel1_next = (in_tag.action == ACT_TEMP);
        j1_next   = IDX_W'(NP - 1);
        for (int j = NP - 2; j >= 1; j--)
        begin
            lxv = sel1_next ? LOG_W'(LOG_U[j]) : LOG_W'(LOG_T[j]);
            if (in_log <= lxv) j1_next = IDX_W'(j);
        end
    end

    // stage 2: table read and offset
    tag_t                      tag2_reg;
    logic signed [DIFF_W-1:0]  diff2_reg;
    logic signed [SLOPE_W-1:0] s2_reg;
    logic signed [LOG_W-1:0]   ly2_reg;
    logic signed [LOG_W-1:0]   l2_reg;
    logic signed [DIFF_W-1:0]  diff2_next;
    logic signed [SLOPE_W-1:0] s2_next;
    logic signed [LOG_W-1:0]   ly2_next;

    always_comb
    begin
        logic signed [LOG_W-1:0]  lx;
        logic signed [DIFF_W-1:0] a;
        logic signed [DIFF_W-1:0] b;
        lx       = sel1_reg ? LOG_W'(LOG_U[j1_reg]) : LOG_W'(LOG_T[j1_reg]);
        ly2_next = sel1_reg ? LOG_W'(LOG_T[j1_reg]) : LOG_W'(LOG_M[j1_reg]);
        s2_next  = sel1_reg ? SLOPE_W'(SLOPE_T[j1_reg]) : SLOPE_W'(SLOPE_MU[j1_reg]);
        a = DIFF_W'(l1_reg);
        b = DIFF_W'(lx);
        diff2_next = a - b;
    end

    // stage 3: partial products over split offset
    tag_t                    tag3_reg;
    logic signed [LOG_W-1:0] ly3_reg;
    logic signed [LOG_W-1:0] l3_reg;
    logic signed [PP_W-1:0]  plo3_reg;
    logic signed [PP_W-1:0]  phi3_reg;
    logic signed [PP_W-1:0]  plo3_next;
    logic signed [PP_W-1:0]  phi3_next;

    assign plo3_next = s2_reg * $signed({1'b0, diff2_reg[17:0]});
    assign phi3_next = s2_reg * $signed(diff2_reg[DIFF_W-1:18]);

    // stage 4: sum, truncate toward zero, add segment base
    tag_t                    tag4_reg;
    logic signed [LOG_W-1:0] l4_reg;
    logic signed [Y_W-1:0]   y4_reg;
    logic signed [Y_W-1:0]   y4_next;

    always_comb
    begin
        logic signed [PROD_W-1:0] a;
        logic signed [PROD_W-1:0] b;
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] q;
        logic signed [Y_W-1:0]    base;
        a    = PROD_W'(phi3_reg);
        b    = PROD_W'(plo3_reg);
        prod = (a <<< 18) + b;
        if (prod[PROD_W-1]) q = (prod + TRUNC_ADJ) >>> FRAC;
        else q = prod >>> FRAC;
        base    = Y_W'(ly3_reg);
        y4_next = Y_W'(q) + base;
    end

    // stage 5: energy difference and exponent bias
    logic                  zero5_reg;
    logic signed [Z_W-1:0] z5_reg;
    logic signed [Z_W-1:0] z5_next;

    always_comb
    begin
        logic signed [Z_W-1:0] l;
        logic signed [Z_W-1:0] y;
        l = Z_W'(l4_reg);
        y = Z_W'(y4_reg);
        if (tag4_reg.action == ACT_ENERGY) z5_next = l - y + Z_OFS;
        else z5_next = y + Z_OFS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v_reg <= '0;
        else if (en) v_reg <= {v_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag1_reg  <= in_tag;
            sel1_reg  <= sel1_next;
            j1_reg    <= j1_next;
            l1_reg    <= in_log;
            tag2_reg  <= tag1_reg;
            diff2_reg <= diff2_next;
            s2_reg    <= s2_next;
            ly2_reg   <= ly2_next;
            l2_reg    <= l1_reg;
            tag3_reg  <= tag2_reg;
            ly3_reg   <= ly2_reg;
            l3_reg    <= l2_reg;
            plo3_reg  <= plo3_next;
            phi3_reg  <= phi3_next;
            tag4_reg  <= tag3_reg;
            l4_reg    <= l3_reg;
            y4_reg    <= y4_next;
            zero5_reg <= tag4_reg.zero;
            z5_reg    <= z5_next;
        end
    end

    assign out_valid = v_reg[4];
    assign out_zero  = zero5_reg;
    assign out_z     = z5_reg;

endmodule

// File: src/llti_exp2.sv
// exp2 back end: classify, one root multiply per stage, final shift and status
`timescale 1ns / 1ps

module llti_exp2
    import llti_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic                  in_zero,
    input  logic signed [Z_W-1:0] in_z,
    output logic                  out_valid,
    output result_t               out_result
);

    typedef struct packed {
        logic              zero;
        logic              tiny;
        logic              sat;
        logic [SHIFT_W-1:0] n;
        logic [FRAC-1:0]   f;
        logic [MANT_W-1:0] mant;
    } estage_t;

    estage_t st_reg  [FRAC+1];
    estage_t st_next [FRAC+1];
    logic    v_reg   [FRAC+1];
    logic    res_valid_reg;
    result_t res_reg;
    result_t res_next;

    always_comb
    begin
        logic [63:0] pr;
        st_next[0].zero = in_zero;
        st_next[0].tiny = in_z[Z_W-1];
        st_next[0].sat  = !in_z[Z_W-1] && ((in_z >>> FRAC) >= Z_W'(56));
        st_next[0].n    = in_z[FRAC+SHIFT_W-1:FRAC];
        st_next[0].f    = in_z[FRAC-1:0];
        st_next[0].mant = MANT_W'(64'd1 << 30);
        for (int k = 1; k <= FRAC; k++)
        begin
            st_next[k] = st_reg[k-1];
            pr = 64'(st_reg[k-1].mant) * ROOTS[k-1];
            if (st_reg[k-1].f[FRAC-k]) st_next[k].mant = MANT_W'(pr >> 30);
        end
    end

    always_comb
    begin
        logic [63:0] w;
        logic [63:0] sh;
        w = 64'(st_reg[FRAC].mant);
        if (st_reg[FRAC].n >= SHIFT_W'(30)) sh = w << (st_reg[FRAC].n - SHIFT_W'(30));
        else sh = w >> (SHIFT_W'(30) - st_reg[FRAC].n);
        if (st_reg[FRAC].zero)
        begin
            res_next.value_out = '0;
            res_next.status    = ST_ZERO;
        end
        else if (st_reg[FRAC].tiny)
        begin
            res_next.value_out = '0;
            res_next.status    = ST_OK;
        end
        else if (st_reg[FRAC].sat)
        begin
            res_next.value_out = '1;
            res_next.status    = ST_SAT;
        end
        else
        begin
            res_next.value_out = sh[VAL_W-1:0];
            res_next.status    = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= FRAC; k++) v_reg[k] <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= FRAC; k++) v_reg[k] <= v_reg[k-1];
            res_valid_reg <= v_reg[FRAC];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= FRAC; k++) st_reg[k] <= st_next[k];
            res_reg <= res_next;
        end
    end

    assign out_valid  = res_valid_reg;
    assign out_result = res_reg;

endmodule

// File: src/loglog_table_interpolator.sv
// top level of the log-log table interpolator pipeline
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-------------------------------
//  input    | item_valid   | item_stall   | item   (action, value_in)
//  output   | result_valid | result_stall | result (value_out, status)
//
// one beat per cycle sustained unless the output stalls; 29 log2 stages
// (normalize plus one 32x32 squaring per fraction bit), 5 interpolation
// stages and 30 exp2 (classify, one root multiply per fraction bit, shift)
// reset clears only the valid bits; the rom is constant logic with no fill
// a stalled output beat freezes the whole pipe, so nothing is lost or repeated
`timescale 1ns / 1ps

module loglog_table_interpolator
    import llti_pkg::*;
#(
    parameter int TABLE_POINTS = TABLE_POINTS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    // whole pipe moves unless a finished beat is held downstream
    logic advance;
    assign advance    = !(result_valid && result_stall);
    assign item_stall = !advance;

    // log2 front end
    logic                    log_valid;
    tag_t                    log_tag;
    logic signed [LOG_W-1:0] log_val;

    llti_log2 u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (item_valid),
        .in_item   (item),
        .out_valid (log_valid),
        .out_tag   (log_tag),
        .out_log   (log_val)
    );

    // segment pick and slope multiply
    logic                  z_valid;
    logic                  z_zero;
    logic signed [Z_W-1:0] z_val;

    llti_interp #(
        .TABLE_POINTS (TABLE_POINTS)
    ) u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (log_valid),
        .in_tag    (log_tag),
        .in_log    (log_val),
        .out_valid (z_valid),
        .out_zero  (z_zero),
        .out_z     (z_val)
    );

    // exp2 back end; its last register is the output beat
    llti_exp2 u_exp2 (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .in_valid   (z_valid),
        .in_zero    (z_zero),
        .in_z       (z_val),
        .out_valid  (result_valid),
        .out_result (result)
    );

endmodule

// File: src/llti_checker.sv
// port-level checks for the interpolator and their bind
`timescale 1ns / 1ps

module llti_checker
    import llti_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result beat changed while stalled");

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled with output free");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_SAT |-> result.value_out == '1)
        else $error("saturated beat without full-scale value");

    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_ZERO |-> result.value_out == '0)
        else $error("zero-input beat with nonzero value");

endmodule

bind loglog_table_interpolator llti_checker u_llti_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// File: verif/tb_loglog_table_interpolator.sv
// self-checking testbench for the log-log table interpolator pipeline
`timescale 1ns / 1ps

module tb_loglog_table_interpolator;
    import llti_pkg::*;

    localparam int NPTS       = 10;
    localparam int N_RANDOM   = 1000;
    localparam int HOLD_LEN   = 200;   // long receiver hold-off, well past the 64-deep pipe
    localparam int DRAIN_WAIT = 100;   // linger for stray beats after the drain
    localparam int WDOG_LIMIT = 3000;
    localparam longint unsigned MAX56 = (64'd1 << 56) - 1;

    // one planned input beat; fixed results are typed in for the obvious rows
    typedef struct {
        item_t   beat;
        bit      has_fixed;
        result_t fixed;
    } plan_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // interpolation tables, built once at time zero
    longint          lt_tab [NPTS];
    longint          lm_tab [NPTS];
    longint          lu_tab [NPTS];
    longint          mu_slope [NPTS];
    longint          temp_slope [NPTS];
    longint unsigned exp_roots [FRAC];

    plan_t   beat_plan [$];
    result_t pending_results [$];
    int      errors = 0;
    int      beats_in = 0;
    int      beats_out = 0;
    int      sender_phase = 0;
    bit      sender_done = 1'b0;

    loglog_table_interpolator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    // log2 of a raw Q24 value as signed Q.28, fraction by repeated squaring
    function automatic longint log2_q28(input longint unsigned x);
        int              msb;
        longint unsigned mant;
        longint          fr;
        fr = 0;
        if (x == 0)
            return -(longint'(24) << FRAC);
        msb = 55;
        while (msb > 0 && x[msb] == 1'b0)
            msb--;
        mant = (msb >= 31) ? (x >> (msb - 31)) : (x << (31 - msb));
        for (int i = 0; i < FRAC; i++)
        begin
            mant = (mant * mant) >> 31;
            fr = fr << 1;
            if (mant >= (64'd1 << 32))
            begin
                mant = mant >> 1;
                fr = fr | 1;
            end
        end
        return (longint'(msb) - 24) * (longint'(1) << FRAC) + fr;
    endfunction

    function automatic longint unsigned sqrt_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // slope dy/dx in Q.28, truncated and clamped
    function automatic longint segment_slope(input longint dy, input longint dx);
        longint s;
        longint lim;
        lim = (longint'(1) << 29) - 1;
        if (dx == 0)
            return 0;
        s = (dy * (longint'(1) << FRAC)) / dx;
        if (s > lim)
            s = lim;
        if (s < -lim)
            s = -lim;
        return s;
    endfunction

    function automatic void build_tables();
        longint unsigned temps [NPTS];
        longint unsigned mus [NPTS];
        longint unsigned c;
        temps = '{10, 100, 1000, 10000, 13000, 21000, 34000, 63000, 100000, 1000000000};
        mus = '{118701555, 115484424, 109603514, 99814960, 96346395, 65175895,
                61429010, 60568330, 58977760, 58822635};
        for (int i = 0; i < NPTS; i++)
        begin
            lt_tab[i] = log2_q28(temps[i] << 24);
            lm_tab[i] = log2_q28(((mus[i] << 24) + 64'd50000000) / 64'd100000000);
            lu_tab[i] = lt_tab[i] - lm_tab[i];
            mu_slope[i] = 0;
            temp_slope[i] = 0;
        end
        for (int i = 1; i < NPTS; i++)
        begin
            mu_slope[i] = segment_slope(lm_tab[i] - lm_tab[i-1], lt_tab[i] - lt_tab[i-1]);
            temp_slope[i] = segment_slope(lt_tab[i] - lt_tab[i-1], lu_tab[i] - lu_tab[i-1]);
        end
        c = 64'd1 << 31;
        for (int i = 0; i < FRAC; i++)
        begin
            c = sqrt_floor(c << 30);
            exp_roots[i] = c;
        end
    endfunction

    // piecewise-linear lookup in the log domain; end segments extend outward
    function automatic longint log_lookup(input bit by_energy, input longint l);
        int     j;
        longint xj;
        j = 1;
        while (j < NPTS - 1 && l > (by_energy ? lu_tab[j] : lt_tab[j]))
            j++;
        xj = by_energy ? lu_tab[j] : lt_tab[j];
        if (by_energy)
            return lt_tab[j] + (temp_slope[j] * (l - xj)) / (longint'(1) << FRAC);
        return lm_tab[j] + (mu_slope[j] * (l - xj)) / (longint'(1) << FRAC);
    endfunction

    // expected output beat for one input beat
    function automatic result_t interpolate_value(input item_t b);
        result_t         r;
        longint          l;
        longint          y;
        longint          z;
        longint          sh;
        longint unsigned fr;
        longint unsigned mant;
        r = '0;
        if (b.value_in == 0)
        begin
            r.status = ST_ZERO;
            return r;
        end
        l = log2_q28(64'(b.value_in));
        if (b.action == ACT_TEMP)
            y = log_lookup(1'b1, l);
        else if (b.action == ACT_ENERGY)
            y = l - log_lookup(1'b0, l);
        else
            y = log_lookup(1'b0, l);   // unused code 3 behaves as weight
        z = y + (longint'(24) << FRAC);
        r.status = ST_OK;
        if (z < 0)
            return r;   // tiny result flushes to zero
        sh = z >>> FRAC;
        if (sh >= 56)
        begin
            r.value_out = MAX56[VAL_W-1:0];
            r.status = ST_SAT;
            return r;
        end
        fr = longint'(z) & ((64'd1 << FRAC) - 1);
        mant = 64'd1 << 30;
        for (int i = 0; i < FRAC; i++)
            if (fr[FRAC-1-i])
                mant = (mant * exp_roots[i]) >> 30;
        mant = (sh >= 30) ? (mant << (sh - 30)) : (mant >> (30 - sh));
        r.value_out = mant[VAL_W-1:0];
        return r;
    endfunction

    function automatic void add_beat(input logic [1:0] act, input longint unsigned v,
                                     input bit fixed_ok, input result_t fx);
        plan_t p;
        p.beat.action = act;
        p.beat.value_in = v[VAL_W-1:0];
        p.has_fixed = fixed_ok;
        p.fixed = fx;
        beat_plan.push_back(p);
    endfunction

    // random value spread over every octave, some raw bit noise and zeros
    function automatic longint unsigned rand_value();
        int              k;
        longint unsigned v;
        case ($urandom_range(0, 19))
            0: return 0;
            1, 2: return {$urandom, $urandom} & MAX56;
            default:
            begin
                k = $urandom_range(0, 55);
                v = {$urandom, $urandom} & ((64'd1 << k) - 1);
                return (64'd1 << k) | v;
            end
        endcase
    endfunction

    function automatic void build_stimulus();
        result_t zr;
        result_t none;
        zr = '0;
        zr.status = ST_ZERO;
        none = '0;
        // zero input on every action code, the unused one included
        for (int a = 0; a < 4; a++)
            add_beat(2'(a), 0, 1'b1, zr);
        for (int a = 0; a < 4; a++)
        begin
            add_beat(2'(a), 1, 1'b0, none);          // smallest nonzero
            add_beat(2'(a), MAX56, 1'b0, none);      // all ones
        end
        add_beat(ACT_WEIGHT, 64'd1 << 24, 1'b0, none);          // below the first point
        add_beat(ACT_WEIGHT, 64'd10 << 24, 1'b0, none);         // first point
        add_beat(ACT_WEIGHT, 64'd13000 << 24, 1'b0, none);      // inner point
        add_beat(ACT_WEIGHT, 64'd1000000000 << 24, 1'b0, none); // last point
        add_beat(ACT_WEIGHT, 64'd4000000000 << 24, 1'b0, none); // beyond the last point
        add_beat(ACT_ENERGY, 64'd50000 << 24, 1'b0, none);
        add_beat(ACT_ENERGY, 64'd1000000000 << 24, 1'b0, none);
        add_beat(ACT_TEMP, 64'd2 << 24, 1'b0, none);
        add_beat(ACT_TEMP, 64'd30000 << 24, 1'b0, none);
        add_beat(ACT_TEMP, 64'd3000000000 << 24, 1'b0, none);
        add_beat(ACT_TEMP, 64'hAAAAAAAAAAAAAA, 1'b0, none);
        add_beat(ACT_ENERGY, 64'h55555555555555, 1'b0, none);
        for (int i = 0; i < N_RANDOM; i++)
            add_beat(($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                     rand_value(), 1'b0, none);
    endfunction

    // sender: walks the plan, idles at random, holds a stalled beat unchanged
    initial
    begin
        int idle_pct;
        int total;
        build_tables();
        build_stimulus();
        total = beat_plan.size();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < total; i++)
        begin
            sender_phase = (i * 3) / total;
            idle_pct = (sender_phase == 0) ? 38 : (sender_phase == 1) ? 51 : 0;
            while ($urandom_range(0, 99) < idle_pct)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
            item_valid <= 1'b1;
            item <= beat_plan[i].beat;
            @(posedge clk);
            while (item_stall)
                @(posedge clk);
            // beat accepted at this edge
            beats_in++;
            if (beat_plan[i].has_fixed)
                pending_results.push_back(beat_plan[i].fixed);
            else
                pending_results.push_back(interpolate_value(beat_plan[i].beat));
        end
        item_valid <= 1'b0;
        sender_done = 1'b1;
    end

    // receiver stall: random per phase plus one long hold-off to back up the pipe
    always @(posedge clk)
    begin
        static int  hold_left = 0;
        static bit  held = 1'b0;
        int         stall_pct;
        if (rst_n)
        begin
            stall_pct = (sender_phase == 0) ? 51 : (sender_phase == 1) ? 38 : 0;
            if (!held && beats_in >= 150)
            begin
                held = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // compare each accepted output beat against the oldest expectation
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && result_valid && !result_stall)
        begin
            beats_out++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat value_out=%h status=%0d",
                         $time, result.value_out, result.status);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (result.value_out !== exp_r.value_out)
                begin
                    errors++;
                    $display("%0t: value_out expected %h actual %h",
                             $time, exp_r.value_out, result.value_out);
                end
                if (result.status !== exp_r.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, result.status);
                end
            end
        end
    end

    // watchdog: cycles with no beat moving on either side
    always @(posedge clk)
    begin
        static int quiet = 0;
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // end of run: drain, then linger for stray beats
    initial
    begin
        wait (sender_done);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: loglog_table_interpolator.f
src/llti_pkg.sv
src/llti_log2.sv
src/llti_interp.sv
src/llti_exp2.sv
src/loglog_table_interpolator.sv
src/llti_checker.sv
verif/tb_loglog_table_interpolator.sv
